/* src/mcsg_pkg.sv */
// Shared types and constants of the midpoint circle span generator.
package mcsg_pkg;

	localparam int COORD_W  = 14;
	localparam int CENTER_W = 12;

	localparam int GQ_PTR_W = 1;
	localparam int GQ_DEPTH = 1 << GQ_PTR_W;

	localparam logic CMD_START = 1'b0;
	localparam logic CMD_STEP  = 1'b1;

	typedef logic [COORD_W-1:0]  coord_t;
	typedef logic [CENTER_W-1:0] center_t;

	// One group of four spans, as handed from the walk stage to the span stage.
	typedef struct packed {
		center_t cx;
		center_t cy;
		coord_t  x;
		coord_t  y;
		logic    done;
	} group_t;

endpackage

/* src/mcsg_front.sv */
// Walk stage: takes commands, steps the midpoint decision and issues span groups.
module mcsg_front import mcsg_pkg::*; #(
	parameter int RADIUS_BITS = 11
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	input  logic                   command,
	input  center_t                center_x,
	input  center_t                center_y,
	input  logic [RADIUS_BITS-1:0] radius,
	input  logic                   q_full,
	output logic                   q_push,
	output group_t                 q_data
);

	localparam int DEC_W = RADIUS_BITS + 5;
	localparam int WK_W  = RADIUS_BITS + 2;

	localparam logic signed [DEC_W-1:0] D_THREE = DEC_W'(3);
	localparam logic signed [DEC_W-1:0] D_SIX   = DEC_W'(6);
	localparam logic signed [DEC_W-1:0] D_TEN   = DEC_W'(10);

	center_t                  cx_q;
	center_t                  cy_q;
	logic [RADIUS_BITS-1:0]   walk_x_q;
	logic [RADIUS_BITS-1:0]   walk_y_q;
	logic signed [DEC_W-1:0]  decision_q;
	logic                     active_q;

	logic                     accept;
	logic                     is_start;
	logic                     emit;
	center_t                  cur_cx;
	center_t                  cur_cy;
	logic [RADIUS_BITS-1:0]   cur_x;
	logic [RADIUS_BITS-1:0]   cur_y;
	logic signed [DEC_W-1:0]  r_ext;
	logic signed [DEC_W-1:0]  x_ext;
	logic signed [DEC_W-1:0]  y_ext;
	logic signed [DEC_W-1:0]  cur_d;
	logic signed [DEC_W-1:0]  next_d;
	logic signed [WK_W-1:0]   next_x;
	logic signed [WK_W-1:0]   next_y;
	logic                     done;

	always_comb begin
		accept   = push && !q_full;
		is_start = (command == CMD_START);
		emit     = accept && (is_start || active_q);

		cur_cx = is_start ? center_x : cx_q;
		cur_cy = is_start ? center_y : cy_q;
		cur_x  = is_start ? '0 : walk_x_q;
		cur_y  = is_start ? radius : walk_y_q;

		r_ext = signed'({{(DEC_W-RADIUS_BITS){1'b0}}, radius});
		x_ext = signed'({{(DEC_W-RADIUS_BITS){1'b0}}, cur_x});
		y_ext = signed'({{(DEC_W-RADIUS_BITS){1'b0}}, cur_y});
		cur_d = is_start ? (D_THREE - (r_ext <<< 1)) : decision_q;

		// A negative decision keeps the row; otherwise the walk moves one row in.
		if (cur_d[DEC_W-1]) begin
			next_d = cur_d + (x_ext <<< 2) + D_SIX;
			next_y = signed'({2'b00, cur_y});
		end else begin
			next_d = cur_d + ((x_ext - y_ext) <<< 2) + D_TEN;
			next_y = signed'({2'b00, cur_y}) - WK_W'(1);
		end
		next_x = signed'({2'b00, cur_x}) + WK_W'(1);
		done   = next_x > next_y;

		q_push      = emit;
		q_data.cx   = cur_cx;
		q_data.cy   = cur_cy;
		q_data.x    = COORD_W'(cur_x);
		q_data.y    = COORD_W'(cur_y);
		q_data.done = done;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cx_q       <= '0;
			cy_q       <= '0;
			walk_x_q   <= '0;
			walk_y_q   <= '0;
			decision_q <= '0;
			active_q   <= 1'b0;
		end else if (emit) begin
			cx_q       <= cur_cx;
			cy_q       <= cur_cy;
			walk_x_q   <= next_x[RADIUS_BITS-1:0];
			walk_y_q   <= next_y[RADIUS_BITS-1:0];
			decision_q <= next_d;
			active_q   <= !done;
		end
	end

endmodule

/* src/mcsg_group_fifo.sv */
// Short queue of span groups between the walk stage and the span stage.
module mcsg_group_fifo import mcsg_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   wr_en,
	input  group_t wr_data,
	output logic   full,
	input  logic   rd_en,
	output group_t rd_data,
	output logic   empty
);

	group_t              mem_q [GQ_DEPTH];
	logic [GQ_PTR_W-1:0] wr_ptr_q;
	logic [GQ_PTR_W-1:0] rd_ptr_q;
	logic [GQ_PTR_W:0]   count_q;
	logic                do_wr;
	logic                do_rd;

	always_comb begin
		full    = (count_q == (GQ_PTR_W+1)'(GQ_DEPTH));
		empty   = (count_q == '0);
		do_wr   = wr_en && !full;
		do_rd   = rd_en && !empty;
		rd_data = mem_q[rd_ptr_q];
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= wr_ptr_q + GQ_PTR_W'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= rd_ptr_q + GQ_PTR_W'(1);
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + (GQ_PTR_W+1)'(1);
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - (GQ_PTR_W+1)'(1);
			end
		end
	end

endmodule

/* src/mcsg_back.sv */
// Span stage: unrolls each group into four spans through an output register.
module mcsg_back import mcsg_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  group_t                    grp,
	input  logic                      grp_empty,
	output logic                      grp_pop,
	output logic                      empty,
	input  logic                      pop,
	output logic signed [COORD_W-1:0] span_row,
	output logic signed [COORD_W-1:0] span_left,
	output logic signed [COORD_W-1:0] span_right,
	output logic                      group_last,
	output logic                      circle_done
);

	typedef enum logic [1:0] {
		PH_ROW_PX,
		PH_ROW_MX,
		PH_ROW_PY,
		PH_ROW_MY
	} phase_t;

	phase_t phase_q;
	phase_t phase_nxt;
	logic   out_valid_q;
	coord_t row_q;
	coord_t left_q;
	coord_t right_q;
	logic   last_q;
	logic   done_q;

	coord_t cx;
	coord_t cy;
	coord_t row_c;
	coord_t left_c;
	coord_t right_c;
	logic   last_c;
	logic   take;
	logic   load;

	always_comb begin
		cx   = COORD_W'(grp.cx);
		cy   = COORD_W'(grp.cy);
		take = pop && out_valid_q;
		load = !grp_empty && (!out_valid_q || take);

		unique case (phase_q)
			PH_ROW_PX: begin
				row_c     = cy + grp.x;
				left_c    = cx - grp.y;
				right_c   = cx + grp.y;
				last_c    = 1'b0;
				phase_nxt = PH_ROW_MX;
			end
			PH_ROW_MX: begin
				row_c     = cy - grp.x;
				left_c    = cx - grp.y;
				right_c   = cx + grp.y;
				last_c    = 1'b0;
				phase_nxt = PH_ROW_PY;
			end
			PH_ROW_PY: begin
				row_c     = cy + grp.y;
				left_c    = cx - grp.x;
				right_c   = cx + grp.x;
				last_c    = 1'b0;
				phase_nxt = PH_ROW_MY;
			end
			PH_ROW_MY: begin
				row_c     = cy - grp.y;
				left_c    = cx - grp.x;
				right_c   = cx + grp.x;
				last_c    = 1'b1;
				phase_nxt = PH_ROW_PX;
			end
			default: begin
				row_c     = '0;
				left_c    = '0;
				right_c   = '0;
				last_c    = 1'b0;
				phase_nxt = PH_ROW_PX;
			end
		endcase

		grp_pop     = load && last_c;
		empty       = !out_valid_q;
		span_row    = signed'(row_q);
		span_left   = signed'(left_q);
		span_right  = signed'(right_q);
		group_last  = last_q;
		circle_done = done_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_ROW_PX;
			out_valid_q <= 1'b0;
			row_q       <= '0;
			left_q      <= '0;
			right_q     <= '0;
			last_q      <= 1'b0;
			done_q      <= 1'b0;
		end else if (load) begin
			phase_q     <= phase_nxt;
			out_valid_q <= 1'b1;
			row_q       <= row_c;
			left_q      <= left_c;
			right_q     <= right_c;
			last_q      <= last_c;
			done_q      <= grp.done;
		end else if (take) begin
			out_valid_q <= 1'b0;
		end
	end

endmodule

/* src/midpoint_circle_span_generator.sv */
// Top level of the filled-circle span generator.
//
//   Channel   Handshake        Payload
//   -------   --------------   ------------------------------------------------
//   command   push / full      command, center_x, center_y, radius
//   spans     pop / empty      span_row, span_left, span_right, group_last,
//                              circle_done
//
// A start or step item that yields spans occupies the span stage for four spans,
// one span per cycle while pop is held, as the single output register of the span
// stage holds each span until it is taken. A step that arrives with no circle in
// progress is absorbed and gives nothing. The first span of an item reaches the
// result ports through the group queue and then the span stage's output register.
// Reset clears the walk state, the group queue and the output register at once;
// no clearing pass follows. A stalled result side fills the two-entry group queue
// before full rises, and a quiet input side leaves the span stage draining.
module midpoint_circle_span_generator import mcsg_pkg::*; #(
	parameter int RADIUS_BITS = 11
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      push,
	output logic                      full,
	input  logic                      command,
	input  logic [CENTER_W-1:0]       center_x,
	input  logic [CENTER_W-1:0]       center_y,
	input  logic [RADIUS_BITS-1:0]    radius,
	output logic                      empty,
	input  logic                      pop,
	output logic signed [COORD_W-1:0] span_row,
	output logic signed [COORD_W-1:0] span_left,
	output logic signed [COORD_W-1:0] span_right,
	output logic                      group_last,
	output logic                      circle_done
);

	// The walk stage hands each group over as its centre and the walk point
	// before the update, plus whether the circle ends with this group.
	logic   q_push;
	logic   q_full;
	group_t q_wdata;
	group_t q_rdata;
	logic   q_empty;
	logic   q_pop;

	// The command side reports full whenever the group queue cannot take more;
	// an idle step is held off then as well, although it would give nothing.
	assign full = q_full;

	mcsg_front #(
		.RADIUS_BITS (RADIUS_BITS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.command  (command),
		.center_x (center_x),
		.center_y (center_y),
		.radius   (radius),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_data   (q_wdata)
	);

	mcsg_group_fifo u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (q_push),
		.wr_data (q_wdata),
		.full    (q_full),
		.rd_en   (q_pop),
		.rd_data (q_rdata),
		.empty   (q_empty)
	);

	// The span stage works through the rows cy+x, cy-x, cy+y and cy-y in turn
	// and releases the queue entry as the fourth span is loaded.
	mcsg_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.grp         (q_rdata),
		.grp_empty   (q_empty),
		.grp_pop     (q_pop),
		.empty       (empty),
		.pop         (pop),
		.span_row    (span_row),
		.span_left   (span_left),
		.span_right  (span_right),
		.group_last  (group_last),
		.circle_done (circle_done)
	);

endmodule

/* dv/mcsg_span_checker.sv */
// Span checker: predicts every span of the circle generator and compares it at the output.
`timescale 1ns / 100ps
module mcsg_span_checker import mcsg_pkg::*; #(
	parameter int RADIUS_BITS = 11
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	input  logic                   full,
	input  logic                   command,
	input  center_t                center_x,
	input  center_t                center_y,
	input  logic [RADIUS_BITS-1:0] radius,
	input  logic                   empty,
	input  logic                   pop,
	input  coord_t                 span_row,
	input  coord_t                 span_left,
	input  coord_t                 span_right,
	input  logic                   group_last,
	input  logic                   circle_done,
	output int                     mismatches,
	output int                     spans_awaited
);

	typedef struct packed {
		coord_t row;
		coord_t left;
		coord_t right;
		logic   last;
		logic   done;
	} span_t;

	span_t expected_spans[$];

	int   circle_cx;
	int   circle_cy;
	int   walk_x;
	int   walk_y;
	int   decision;
	logic in_circle;

	// Queues the four spans of the current group and advances the walk.
	function automatic void trace_group();
		int   x;
		int   y;
		logic done;
		x = walk_x;
		y = walk_y;
		if (decision < 0) begin
			decision += 4 * x + 6;
		end else begin
			decision += 4 * (x - y) + 10;
			walk_y = y - 1;
		end
		walk_x = x + 1;
		done = walk_x > walk_y;
		if (done) begin
			in_circle = 1'b0;
		end
		expected_spans.push_back('{coord_t'(circle_cy + x), coord_t'(circle_cx - y),
			coord_t'(circle_cx + y), 1'b0, done});
		expected_spans.push_back('{coord_t'(circle_cy - x), coord_t'(circle_cx - y),
			coord_t'(circle_cx + y), 1'b0, done});
		expected_spans.push_back('{coord_t'(circle_cy + y), coord_t'(circle_cx - x),
			coord_t'(circle_cx + x), 1'b0, done});
		expected_spans.push_back('{coord_t'(circle_cy - y), coord_t'(circle_cx - x),
			coord_t'(circle_cx + x), 1'b1, done});
	endfunction

	function automatic int field_differs(string field, int want, int got);
		if (want == got) begin
			return 0;
		end
		$error("%s: expected %0d, got %0d", field, want, got);
		return 1;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		span_t want;
		int    bad;
		if (!arst_n) begin
			circle_cx = 0;
			circle_cy = 0;
			walk_x = 0;
			walk_y = 0;
			decision = 0;
			in_circle = 1'b0;
			expected_spans.delete();
			mismatches <= 0;
			spans_awaited <= 0;
		end else begin
			bad = 0;
			if (pop && !empty) begin
				if (expected_spans.size() == 0) begin
					$error("span transfer with no span expected: row %0d", $signed(span_row));
					bad = 1;
				end else begin
					want = expected_spans.pop_front();
					bad += field_differs("span_row", $signed(want.row), $signed(span_row));
					bad += field_differs("span_left", $signed(want.left), $signed(span_left));
					bad += field_differs("span_right", $signed(want.right),
						$signed(span_right));
					bad += field_differs("group_last", want.last, group_last);
					bad += field_differs("circle_done", want.done, circle_done);
				end
			end
			if (push && !full) begin
				if (command == CMD_START) begin
					circle_cx = center_x;
					circle_cy = center_y;
					walk_x = 0;
					walk_y = radius;
					decision = 3 - 2 * int'(radius);
					in_circle = 1'b1;
					trace_group();
				end else if (in_circle && walk_x <= walk_y) begin
					trace_group();
				end else begin
					in_circle = 1'b0;
				end
			end
			mismatches <= mismatches + bad;
			spans_awaited <= expected_spans.size();
		end
	end

endmodule

/* dv/tb_midpoint_circle_span_generator.sv */
// Testbench top of the filled-circle span generator: stimulus, flow control and verdict.
`timescale 1ns / 100ps
module tb_midpoint_circle_span_generator import mcsg_pkg::*;;

	localparam int RADIUS_BITS = 11;
	// Far beyond the slowest correct run: every item stalled on both sides for the full
	// burst length, plus the long hold-off and the pauses.
	localparam int CYCLE_LIMIT = 250000;
	localparam int ITEM_TARGET = 300;
	localparam int CALM_ITEMS  = 40;
	localparam int HOLD_CYCLES = 400;

	logic                   clk;
	logic                   arst_n;
	logic                   push;
	logic                   full;
	logic                   command;
	center_t                center_x;
	center_t                center_y;
	logic [RADIUS_BITS-1:0] radius;
	logic                   empty;
	logic                   pop;
	coord_t                 span_row;
	coord_t                 span_left;
	coord_t                 span_right;
	logic                   group_last;
	logic                   circle_done;

	int   mismatches;
	int   spans_awaited;
	int   cycles = 0;
	int   items_sent;
	// Set for the closing stretch of the run, in which neither side idles.
	logic calm;

	midpoint_circle_span_generator #(.RADIUS_BITS(RADIUS_BITS)) dut (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .command(command),
		.center_x(center_x), .center_y(center_y), .radius(radius), .empty(empty),
		.pop(pop), .span_row(span_row), .span_left(span_left), .span_right(span_right),
		.group_last(group_last), .circle_done(circle_done)
	);

	mcsg_span_checker #(.RADIUS_BITS(RADIUS_BITS)) span_check (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .command(command),
		.center_x(center_x), .center_y(center_y), .radius(radius), .empty(empty),
		.pop(pop), .span_row(span_row), .span_left(span_left), .span_right(span_right),
		.group_last(group_last), .circle_done(circle_done), .mismatches(mismatches),
		.spans_awaited(spans_awaited)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// The run is abandoned if it goes on far longer than any correct run could.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("tb_midpoint_circle_span_generator: done, errors");
			$finish;
		end
	end

	// Offers one item and waits for the edge on which its transfer happens. Push is left
	// high, so that a following item keeps the input busy without a gap; the random idle
	// bursts fall between items here unless the run has reached its calm stretch.
	task automatic offer(input logic cmd, input center_t cx, input center_t cy,
		input logic [RADIUS_BITS-1:0] r);
		command <= cmd;
		center_x <= cx;
		center_y <= cy;
		radius <= r;
		push <= 1'b1;
		do @(posedge clk); while (full);
		items_sent++;
		if (!calm && $urandom_range(0, 7) == 0) begin
			push <= 1'b0;
			repeat ($urandom_range(1, 19)) @(posedge clk);
		end
	endtask

	// Stops offering and waits until every span that has been predicted has arrived.
	// The checker registers its count, so the count is read only after waiting on the clock.
	task automatic settle();
		push <= 1'b0;
		do @(posedge clk); while (spans_awaited != 0);
	endtask

	// Stimulus.
	initial begin
		int                     seq_kind;
		int                     steps;
		int                     n;
		logic [RADIUS_BITS-1:0] r;
		items_sent = 0;
		calm = 1'b0;
		arst_n <= 1'b0;
		push <= 1'b0;
		command <= CMD_STEP;
		center_x <= '0;
		center_y <= '0;
		radius <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// A step straight after reset finds no circle and must give nothing.
		offer(CMD_STEP, 12'hFFF, 12'hFFF, 11'h7FF);
		// Radius zero at the origin: one group of single pixels, flagged done.
		offer(CMD_START, 12'h000, 12'h000, 11'h000);
		// A step after the circle has finished is absorbed silently.
		offer(CMD_STEP, 12'h000, 12'h000, 11'h000);
		// Largest centre and radius, so the right edges reach furthest.
		offer(CMD_START, 12'hFFF, 12'hFFF, 11'h7FF);
		repeat (3) offer(CMD_STEP, 12'h000, 12'h000, 11'h000);
		// A start while that circle is still being walked abandons it; radius one
		// finishes in a single group.
		offer(CMD_START, 12'hFFF, 12'h000, 11'h001);
		offer(CMD_STEP, 12'hFFF, 12'hFFF, 11'h7FF);
		// Largest radius at the opposite corner drives the left columns negative.
		offer(CMD_START, 12'h000, 12'hFFF, 11'h7FF);
		repeat (2) offer(CMD_STEP, 12'h000, 12'h000, 11'h000);
		// A small circle walked right through to its last group and two steps beyond.
		offer(CMD_START, 12'h800, 12'h800, 11'd5);
		repeat (5) offer(CMD_STEP, 12'h000, 12'h000, 11'h000);
		// Alternating bit patterns on every field.
		offer(CMD_START, 12'h555, 12'hAAA, 11'h2AA);
		offer(CMD_STEP, 12'hAAA, 12'h555, 11'h555);
		offer(CMD_START, 12'hAAA, 12'h555, 11'h555);
		offer(CMD_STEP, 12'h555, 12'hAAA, 11'h2AA);
		settle();

		// Random part: mostly whole circles with random centres, a few walked only
		// partway, and some noise of arbitrary commands in between.
		while (items_sent < ITEM_TARGET) begin
			if (items_sent >= ITEM_TARGET - CALM_ITEMS) begin
				calm = 1'b1;
			end
			seq_kind = $urandom_range(0, 9);
			if (seq_kind <= 6) begin
				if ($urandom_range(0, 7) == 0) begin
					r = RADIUS_BITS'($urandom_range(0, (1 << RADIUS_BITS) - 1));
					steps = $urandom_range(1, 6);
				end else begin
					r = RADIUS_BITS'($urandom_range(0, 24));
					// The walk ends after roughly r / sqrt(2) steps; run a little past it.
					steps = (int'(r) * 3) / 4 + $urandom_range(1, 2);
					if ($urandom_range(0, 4) == 0) begin
						steps = $urandom_range(0, steps);
					end
				end
				offer(CMD_START, center_t'($urandom), center_t'($urandom), r);
				for (n = 0; n < steps; n++) begin
					offer(CMD_STEP, center_t'($urandom), center_t'($urandom),
						RADIUS_BITS'($urandom));
				end
			end else begin
				repeat ($urandom_range(1, 4)) begin
					offer(1'($urandom), center_t'($urandom), center_t'($urandom),
						RADIUS_BITS'($urandom_range(0, 30)));
				end
			end
			// Midway, from half the target to 25 items past it, the sender waits for the block to empty completely.
			if (items_sent >= ITEM_TARGET / 2 && items_sent < ITEM_TARGET / 2 + 25 &&
				!calm) begin
				settle();
			end
		end

		settle();
		repeat (10) @(posedge clk);
		if (mismatches == 0) begin
			$display("tb_midpoint_circle_span_generator: done, clean");
		end else begin
			$display("tb_midpoint_circle_span_generator: done, errors");
		end
		$finish;
	end

	// Result side. Pop idles in random bursts until the calm stretch; once, after 120 spans
	// have been taken, it makes the long hold-off while the sender keeps offering, so that
	// the group queue fills and full is raised against the sender.
	initial begin
		int   spans_taken;
		logic held_long;
		spans_taken = 0;
		held_long = 1'b0;
		pop <= 1'b0;
		@(posedge arst_n);
		forever begin
			if (!calm && !held_long && spans_taken >= 120) begin
				pop <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				held_long = 1'b1;
			end else if (!calm && $urandom_range(0, 9) == 0) begin
				pop <= 1'b0;
				repeat ($urandom_range(1, 19)) @(posedge clk);
			end else begin
				pop <= 1'b1;
				@(posedge clk);
				if (!empty) begin
					spans_taken++;
				end
			end
		end
	end

endmodule

/* sim.f */
src/mcsg_pkg.sv
src/mcsg_front.sv
src/mcsg_group_fifo.sv
src/mcsg_back.sv
src/midpoint_circle_span_generator.sv
dv/mcsg_span_checker.sv
dv/tb_midpoint_circle_span_generator.sv
